// File: src/ssram_pkg.sv
// shared types and constants for the serial sram slave
package ssram_pkg;

    localparam int ADDR_BITS = 17;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [7:0] CMD_WRMR  = 8'h01;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] MODE_SEQ  = 8'h40;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [7:0] {
        PH_CMD    = 8'b0000_0001,
        PH_MODE   = 8'b0000_0010,
        PH_ADDR0  = 8'b0000_0100,
        PH_ADDR1  = 8'b0000_1000,
        PH_ADDR2  = 8'b0001_0000,
        PH_WDATA  = 8'b0010_0000,
        PH_RDATA  = 8'b0100_0000,
        PH_IGNORE = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic       en;
        logic       we;
        addr_t      addr;
        logic [7:0] wdata;
    } mem_req_t;

endpackage

// File: src/ssram_mem.sv
// byte-wide single-port storage array with registered read data
module ssram_mem
    import ssram_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/spi_serial_sram_slave.sv
// serial sram slave, sequential mode: frame decoder, storage and result register
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | cmd, mosi_byte
//  out     | out_valid / out_ready| miso_byte, read_valid, mode_value
//
// one item per cycle sustained while the output is not stalled; each item passes
// through the read data stage (decode and storage access) and then the
// result register. the storage port is used at most once per item.
// reset returns the frame decoder to the command byte and mode to 0x40;
// storage contents are not cleared. a stalled output holds the read data
// stage, and the input stalls only when both later stages are full.
module spi_serial_sram_slave
    import ssram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] mosi_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] miso_byte,
    output logic       read_valid,
    output logic [7:0] mode_value
);

    phase_t     phase_reg, phase_next;
    addr_t      addr_reg, addr_next;
    logic       rdir_reg, rdir_next;
    logic [7:0] mode_reg, mode_next;

    logic       p1_valid_reg;
    logic       p1_read_reg;
    logic [7:0] p1_mode_reg;

    logic       out_valid_reg;
    logic [7:0] out_miso_reg;
    logic       out_read_reg;
    logic [7:0] out_mode_reg;

    logic       accept;
    logic       p1_advance;
    logic       is_read;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic [ADDR_BITS+7:0] addr_shift;

    assign p1_advance = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !p1_valid_reg || !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign addr_shift = {addr_reg, mosi_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        rdir_next     = rdir_reg;
        mode_next     = mode_reg;
        is_read       = 1'b0;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = addr_reg;
        mem_req.wdata = mosi_byte;
        if (accept)
        begin
            if (cmd)
            begin
                phase_next = PH_CMD;
            end
            else
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (mosi_byte == CMD_WRMR)
                        begin
                            phase_next = PH_MODE;
                        end
                        else if (mosi_byte == CMD_WRITE || mosi_byte == CMD_READ)
                        begin
                            rdir_next  = (mosi_byte == CMD_READ);
                            phase_next = PH_ADDR0;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    PH_MODE:
                    begin
                        mode_next  = mosi_byte;
                        phase_next = PH_IGNORE;
                    end
                    PH_ADDR0:
                    begin
                        addr_next  = addr_shift[ADDR_BITS-1:0];
                        phase_next = PH_ADDR1;
                    end
                    PH_ADDR1:
                    begin
                        addr_next  = addr_shift[ADDR_BITS-1:0];
                        phase_next = PH_ADDR2;
                    end
                    PH_ADDR2:
                    begin
                        addr_next  = addr_shift[ADDR_BITS-1:0];
                        phase_next = rdir_reg ? PH_RDATA : PH_WDATA;
                    end
                    PH_WDATA:
                    begin
                        mem_req.en = 1'b1;
                        mem_req.we = 1'b1;
                        addr_next  = addr_reg + addr_t'(1);
                    end
                    PH_RDATA:
                    begin
                        mem_req.en = 1'b1;
                        is_read    = 1'b1;
                        addr_next  = addr_reg + addr_t'(1);
                    end
                    PH_IGNORE:
                    begin
                        phase_next = PH_IGNORE;
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end
    end

    ssram_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            addr_reg      <= '0;
            rdir_reg      <= 1'b0;
            mode_reg      <= MODE_SEQ;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            rdir_reg  <= rdir_next;
            mode_reg  <= mode_next;
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_read_reg <= is_read;
            p1_mode_reg <= mode_next;
        end
        if (p1_advance)
        begin
            out_miso_reg <= p1_read_reg ? mem_rdata : 8'h00;
            out_read_reg <= p1_read_reg;
            out_mode_reg <= p1_mode_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign miso_byte  = out_miso_reg;
    assign read_valid = out_read_reg;
    assign mode_value = out_mode_reg;

endmodule

// File: sim/spi_serial_sram_slave_test.sv
// self-checking testbench for the serial sram slave, driven one spi byte item at a time
module spi_serial_sram_slave_test;
    import ssram_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int PHASE_LEN    = 175;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 10;

    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    typedef struct packed {
        logic       cs_release;
        logic [7:0] data;
    } spi_xfer_t;

    typedef struct packed {
        logic [7:0] miso;
        logic       rd;
        logic [7:0] mode;
    } sram_reply_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       cmd       = 1'b0;
    logic [7:0] mosi_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] miso_byte;
    logic       read_valid;
    logic [7:0] mode_value;

    spi_xfer_t   pending_xfers[$];
    sram_reply_t expected_replies[$];
    addr_t       run_start[$];
    int          run_len[$];

    int items_total  = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int fault_count  = 0;
    int hold_left    = 0;
    bit hold_armed   = 1'b1;

    // device image used for prediction
    phase_t     dev_phase   = PH_CMD;
    addr_t      dev_addr    = '0;
    logic [7:0] dev_mode    = MODE_SEQ;
    logic       dev_reading = 1'b0;
    logic [7:0] mem_image [addr_t];

    spi_serial_sram_slave u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .mosi_byte  (mosi_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .miso_byte  (miso_byte),
        .read_valid (read_valid),
        .mode_value (mode_value)
    );

    always #10 clk = ~clk;

    function automatic sram_reply_t predict_reply(input logic cs_release, input logic [7:0] b);
        sram_reply_t r;
        r = '0;
        if (cs_release)
        begin
            dev_phase = PH_CMD;
        end
        else
        begin
            case (dev_phase)
                PH_CMD:
                begin
                    if (b == CMD_WRMR)
                        dev_phase = PH_MODE;
                    else if (b == CMD_WRITE || b == CMD_READ)
                    begin
                        dev_reading = (b == CMD_READ);
                        dev_phase   = PH_ADDR0;
                    end
                    else
                        dev_phase = PH_IGNORE;
                end
                PH_MODE:
                begin
                    dev_mode  = b;
                    dev_phase = PH_IGNORE;
                end
                PH_ADDR0:
                begin
                    dev_addr  = addr_t'({dev_addr, b});
                    dev_phase = PH_ADDR1;
                end
                PH_ADDR1:
                begin
                    dev_addr  = addr_t'({dev_addr, b});
                    dev_phase = PH_ADDR2;
                end
                PH_ADDR2:
                begin
                    dev_addr  = addr_t'({dev_addr, b});
                    dev_phase = dev_reading ? PH_RDATA : PH_WDATA;
                end
                PH_WDATA:
                begin
                    mem_image[dev_addr] = b;
                    dev_addr = dev_addr + addr_t'(1);
                end
                PH_RDATA:
                begin
                    r.miso   = mem_image.exists(dev_addr) ? mem_image[dev_addr] : 8'h00;
                    r.rd     = 1'b1;
                    dev_addr = dev_addr + addr_t'(1);
                end
                default:
                begin
                end
            endcase
        end
        r.mode = dev_mode;
        return r;
    endfunction

    function automatic traffic_t traffic_phase();
        return traffic_t'((items_taken / PHASE_LEN) % 4);
    endfunction

    task automatic push_xfer(input logic cs_release, input logic [7:0] data);
        spi_xfer_t x;
        x.cs_release = cs_release;
        x.data       = data;
        pending_xfers.push_back(x);
    endtask

    // three address bytes, bits above the address width random
    task automatic send_address(input addr_t a);
        logic [23:0] wide;
        wide = 24'($urandom);
        wide[ADDR_BITS-1:0] = a;
        push_xfer(1'b0, wide[23:16]);
        push_xfer(1'b0, wide[15:8]);
        push_xfer(1'b0, wide[7:0]);
    endtask

    task automatic write_frame(input addr_t start, input logic [7:0] data[$]);
        push_xfer(1'b0, CMD_WRITE);
        send_address(start);
        foreach (data[i])
            push_xfer(1'b0, data[i]);
        push_xfer(1'b1, 8'($urandom));
        if (data.size() != 0)
        begin
            run_start.push_back(start);
            run_len.push_back(data.size());
        end
    endtask

    task automatic read_frame(input addr_t start, input int len);
        push_xfer(1'b0, CMD_READ);
        send_address(start);
        repeat (len)
            push_xfer(1'b0, 8'($urandom));
        push_xfer(1'b1, 8'($urandom));
    endtask

    task automatic mode_frame(input logic [7:0] value, input int extra);
        push_xfer(1'b0, CMD_WRMR);
        push_xfer(1'b0, value);
        repeat (extra)
            push_xfer(1'b0, 8'($urandom));
        push_xfer(1'b1, 8'($urandom));
    endtask

    task automatic unknown_frame(input logic [7:0] code, input int extra);
        push_xfer(1'b0, code);
        repeat (extra)
            push_xfer(1'b0, 8'($urandom));
        push_xfer(1'b1, 8'($urandom));
    endtask

    // access frame cut off inside the address bytes
    task automatic short_addr_frame(input logic [7:0] code, input int addr_bytes);
        push_xfer(1'b0, code);
        repeat (addr_bytes)
            push_xfer(1'b0, 8'($urandom));
        push_xfer(1'b1, 8'($urandom));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        spi_xfer_t nxt;
        int        pct;
        bit        gap;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cmd       <= 1'b0;
            mosi_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(predict_reply(cmd, mosi_byte));
                items_taken <= items_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                case (traffic_phase())
                    TRAFFIC_SEND_GAPS: pct = 46;
                    TRAFFIC_BOTH:      pct = 16;
                    default:           pct = 0;
                endcase
                // keep offering items while the receiver is held off
                gap = (hold_left == 0) && ($urandom_range(0, 99) < pct);
                if (pending_xfers.size() != 0 && !gap)
                begin
                    nxt = pending_xfers.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= nxt.cs_release;
                    mosi_byte <= nxt.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && items_taken >= HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sram_reply_t want;
        int          pct;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_replies.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("reply %0d arrived with nothing expected", results_seen);
                    fault_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (miso_byte !== want.miso || read_valid !== want.rd
                        || mode_value !== want.mode)
                    begin
                        if (fault_count < 10)
                            $display({"mismatch at reply %0d: miso exp %02h got %02h, ",
                                      "read_valid exp %0b got %0b, mode exp %02h got %02h"},
                                     results_seen, want.miso, miso_byte, want.rd, read_valid,
                                     want.mode, mode_value);
                        fault_count++;
                    end
                end
            end
            case (traffic_phase())
                TRAFFIC_RECV_STALLS: pct = 46;
                TRAFFIC_BOTH:        pct = 16;
                default:             pct = 0;
            endcase
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= pct);
        end
    end

    initial
    begin
        logic [7:0] bytes[$];
        logic [7:0] code;
        addr_t      start;
        int         pick;
        int         len;
        int         k;
        int         off;
        int         target;

        // directed frames
        mode_frame(8'hFF, 1);
        bytes = '{8'hFF, 8'h00};
        write_frame(addr_t'(MEM_DEPTH - 1), bytes);   // wraps to location zero
        read_frame(addr_t'(MEM_DEPTH - 1), 2);
        unknown_frame(8'h00, 1);
        mode_frame(8'h00, 0);
        short_addr_frame(CMD_READ, 1);
        push_xfer(1'b1, 8'hFF);                       // release with no frame open

        target = pending_xfers.size() + RANDOM_ITEMS;
        while (pending_xfers.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                case ($urandom_range(0, 9))
                    0:       start = addr_t'(MEM_DEPTH - $urandom_range(1, 6));
                    1:       start = addr_t'($urandom_range(0, 6));
                    default: start = addr_t'($urandom);
                endcase
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32)
                                                  : $urandom_range(0, 8);
                bytes.delete();
                repeat (len)
                    bytes.push_back(8'($urandom));
                write_frame(start, bytes);
            end
            else if (pick < 70 && run_start.size() != 0)
            begin
                // stay inside a written run so every location read is defined
                k   = $urandom_range(0, run_start.size() - 1);
                off = $urandom_range(0, run_len[k] - 1);
                len = $urandom_range(0, run_len[k] - off);
                read_frame(addr_t'(run_start[k] + off), len);
            end
            else if (pick < 78)
                mode_frame(8'($urandom), $urandom_range(0, 2));
            else if (pick < 86)
            begin
                do
                    code = 8'($urandom);
                while (code == CMD_WRMR || code == CMD_WRITE || code == CMD_READ);
                unknown_frame(code, $urandom_range(0, 4));
            end
            else if (pick < 94)
                short_addr_frame($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                                 $urandom_range(0, 2));
            else
                push_xfer(1'b1, 8'($urandom));
        end
        items_total = pending_xfers.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken != items_total || results_seen != items_total)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0 && expected_replies.size() == 0)
            $display("spi_serial_sram_slave verification clean");
        else
            $display("spi_serial_sram_slave verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("spi_serial_sram_slave verification failed");
        $finish;
    end

endmodule
